@@ hw/rtl/nnsa_pkg.sv @@
// Shared types, constants and helper functions for the nearest-neighbor
// scale address generator. No dependencies.
package nnsa_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DIM_W      = 13;   // width and height register width
   localparam int SLICE_W    = 9;    // slice count register width
   localparam int PB_W       = 4;    // pixel_bytes register width
   localparam int RATIO_W    = 28;   // unsigned 12.16 ratio
   localparam int COORD_W    = 12;   // x and y coordinate width
   localparam int ZCOORD_W   = 8;    // slice coordinate width
   localparam int ROW_W      = 20;   // z*H + y
   localparam int PIX_W      = 32;   // (z*H + y)*W + x
   localparam int OFF_W      = 35;   // byte offset

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 28;

   localparam logic [DIM_W-1:0]   MAX_DIM         = DIM_W'(4096);
   localparam logic [SLICE_W-1:0] MAX_SLICES      = SLICE_W'(256);
   localparam logic [PB_W-1:0]    MAX_PIXEL_BYTES = PB_W'(8);
   localparam logic [RATIO_W-1:0] RATIO_ONE       = RATIO_W'(65536);

   localparam logic [CSR_INDEX_W-1:0] REG_SRC_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SRC_SLICES  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PIXEL_BYTES = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_RATIO_X     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_RATIO_Y     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_RATIO_Z     = 3'd6;

   typedef struct packed {
      logic [DIM_W-1:0]    width;
      logic [DIM_W-1:0]    height;
      logic [PB_W-1:0]     pixel_bytes;
      logic [RATIO_W-1:0]  ratio_x;
      logic [RATIO_W-1:0]  ratio_y;
      logic [RATIO_W-1:0]  ratio_z;
      logic [COORD_W-1:0]  x_limit;
      logic [COORD_W-1:0]  y_limit;
      logic [ZCOORD_W-1:0] z_limit;
   } cfg_type;

   // A size of zero acts as one; larger sizes saturate at the maximum.
   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > MAX_DIM) begin
         r = MAX_DIM;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [SLICE_W-1:0] sat_slices(input logic [SLICE_W-1:0] v);
      logic [SLICE_W-1:0] r;
      if (v == '0) begin
         r = SLICE_W'(1);
      end else if (v > MAX_SLICES) begin
         r = MAX_SLICES;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [PB_W-1:0] sat_pixel_bytes(input logic [PB_W-1:0] v);
      logic [PB_W-1:0] r;
      if (v > MAX_PIXEL_BYTES) begin
         r = MAX_PIXEL_BYTES;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/nnsa_cfg.sv @@
// Configuration registers of the scale address generator.
// Depends on nnsa_pkg; stores sizes already saturated and derives axis limits.
module nnsa_cfg import nnsa_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic [SLICE_W-1:0] slices_ff, slices_in;
   logic [PB_W-1:0]    pb_ff, pb_in;
   logic [RATIO_W-1:0] ratio_x_ff, ratio_x_in;
   logic [RATIO_W-1:0] ratio_y_ff, ratio_y_in;
   logic [RATIO_W-1:0] ratio_z_ff, ratio_z_in;
   logic [SLICE_W-1:0] slices_m1;

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      slices_in  = slices_ff;
      pb_in      = pb_ff;
      ratio_x_in = ratio_x_ff;
      ratio_y_in = ratio_y_ff;
      ratio_z_in = ratio_z_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_SRC_WIDTH:   width_in   = sat_dim(csr_wdata[DIM_W-1:0]);
            REG_SRC_HEIGHT:  height_in  = sat_dim(csr_wdata[DIM_W-1:0]);
            REG_SRC_SLICES:  slices_in  = sat_slices(csr_wdata[SLICE_W-1:0]);
            REG_PIXEL_BYTES: pb_in      = sat_pixel_bytes(csr_wdata[PB_W-1:0]);
            REG_RATIO_X:     ratio_x_in = csr_wdata[RATIO_W-1:0];
            REG_RATIO_Y:     ratio_y_in = csr_wdata[RATIO_W-1:0];
            REG_RATIO_Z:     ratio_z_in = csr_wdata[RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= DIM_W'(1);
         height_ff  <= DIM_W'(1);
         slices_ff  <= SLICE_W'(1);
         pb_ff      <= PB_W'(1);
         ratio_x_ff <= RATIO_ONE;
         ratio_y_ff <= RATIO_ONE;
         ratio_z_ff <= RATIO_ONE;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         slices_ff  <= slices_in;
         pb_ff      <= pb_in;
         ratio_x_ff <= ratio_x_in;
         ratio_y_ff <= ratio_y_in;
         ratio_z_ff <= ratio_z_in;
      end
   end

   assign slices_m1 = slices_ff - SLICE_W'(1);

   always_comb begin
      cfg.width       = width_ff;
      cfg.height      = height_ff;
      cfg.pixel_bytes = pb_ff;
      cfg.ratio_x     = ratio_x_ff;
      cfg.ratio_y     = ratio_y_ff;
      cfg.ratio_z     = ratio_z_ff;
      cfg.x_limit     = COORD_W'(width_ff - DIM_W'(1));
      cfg.y_limit     = COORD_W'(height_ff - DIM_W'(1));
      cfg.z_limit     = slices_m1[ZCOORD_W-1:0];
   end

endmodule

@@ hw/rtl/nnsa_axis.sv @@
// One axis mapping: ratio times destination coordinate, round half up,
// clamp to the source limit. Two register stages. Depends on nnsa_pkg.
module nnsa_axis import nnsa_pkg::*; #(
   parameter int DST_W = 12,
   parameter int OUT_W = 12
) (
   input  logic               clock,
   input  logic [DST_W-1:0]   dst,
   input  logic [RATIO_W-1:0] ratio,
   input  logic [OUT_W-1:0]   limit,
   output logic [OUT_W-1:0]   coord
);

   localparam int PROD_W = RATIO_W + DST_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int RND_W  = SUM_W - FRAC_BITS;
   localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [OUT_W-1:0]  coord_ff, coord_in;
   logic [SUM_W-1:0]  sum;
   logic [RND_W-1:0]  rounded;

   assign prod_in = ratio * dst;

   always_comb begin
      sum     = {1'b0, prod_ff} + HALF;
      rounded = sum[SUM_W-1:FRAC_BITS];
      if (rounded > RND_W'(limit)) begin
         coord_in = limit;
      end else begin
         coord_in = rounded[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      coord_ff <= coord_in;
   end

   assign coord = coord_ff;

endmodule

@@ hw/rtl/nnsa_offset.sv @@
// Byte offset of the chosen source pixel, ((z*H + y)*W + x)*pixel_bytes,
// over three register stages with the coordinates carried alongside. Uses nnsa_pkg.
module nnsa_offset import nnsa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [COORD_W-1:0]  in_x,
   input  logic [COORD_W-1:0]  in_y,
   input  logic [ZCOORD_W-1:0] in_z,
   input  cfg_type             cfg,
   output logic                out_valid,
   output logic [COORD_W-1:0]  out_x,
   output logic [COORD_W-1:0]  out_y,
   output logic [ZCOORD_W-1:0] out_z,
   output logic [OFF_W-1:0]    out_offset
);

   logic [2:0] valid_ff, valid_in;

   logic [COORD_W-1:0]  x3_ff, x4_ff, x5_ff;
   logic [COORD_W-1:0]  y3_ff, y4_ff, y5_ff;
   logic [ZCOORD_W-1:0] z3_ff, z4_ff, z5_ff;

   logic [ROW_W-1:0] row_ff, row_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic [OFF_W-1:0] off_ff, off_in;

   logic [ZCOORD_W+DIM_W-1:0] zh;
   logic [ROW_W+DIM_W-1:0]    rw;
   logic [PIX_W+PB_W-1:0]     pb_prod;

   assign valid_in = {valid_ff[1:0], in_valid};

   always_comb begin
      zh      = in_z * cfg.height;
      row_in  = ROW_W'(zh) + ROW_W'(in_y);
      rw      = row_ff * cfg.width;
      pix_in  = PIX_W'(rw) + PIX_W'(x3_ff);
      pb_prod = pix_ff * cfg.pixel_bytes;
      off_in  = pb_prod[OFF_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      x3_ff  <= in_x;
      y3_ff  <= in_y;
      z3_ff  <= in_z;
      pix_ff <= pix_in;
      x4_ff  <= x3_ff;
      y4_ff  <= y3_ff;
      z4_ff  <= z3_ff;
      off_ff <= off_in;
      x5_ff  <= x4_ff;
      y5_ff  <= y4_ff;
      z5_ff  <= z4_ff;
   end

   assign out_valid  = valid_ff[2];
   assign out_x      = x5_ff;
   assign out_y      = y5_ff;
   assign out_z      = z5_ff;
   assign out_offset = off_ff;

endmodule

@@ hw/rtl/nearest_neighbor_scale_address_core.sv @@
// Nearest-neighbor scale address generator, top level. Uses nnsa_pkg,
// nnsa_cfg, nnsa_axis and nnsa_offset.
// A start transfer passes the two axis stages and then the three offset stages to its rsp_valid strobe.
// Throughput: one transfer per cycle; busy stays low, the five-stage pipeline never stalls.
// Reset clears all valid bits and restores the register defaults.
module nearest_neighbor_scale_address_core import nnsa_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [COORD_W-1:0]     req_dst_x,
   input  logic [COORD_W-1:0]     req_dst_y,
   input  logic [ZCOORD_W-1:0]    req_dst_z,
   output logic                   rsp_valid,
   output logic [COORD_W-1:0]     rsp_src_x,
   output logic [COORD_W-1:0]     rsp_src_y,
   output logic [ZCOORD_W-1:0]    rsp_src_z,
   output logic [OFF_W-1:0]       rsp_byte_offset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;

   logic                accept;
   logic [1:0]          valid_ff, valid_in;
   logic [COORD_W-1:0]  sx;
   logic [COORD_W-1:0]  sy;
   logic [ZCOORD_W-1:0] sz;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign valid_in = {valid_ff[0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   nnsa_cfg u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   nnsa_axis #(.DST_W(COORD_W), .OUT_W(COORD_W)) u_axis_x (
      .clock (clock),
      .dst   (req_dst_x),
      .ratio (cfg.ratio_x),
      .limit (cfg.x_limit),
      .coord (sx)
   );

   nnsa_axis #(.DST_W(COORD_W), .OUT_W(COORD_W)) u_axis_y (
      .clock (clock),
      .dst   (req_dst_y),
      .ratio (cfg.ratio_y),
      .limit (cfg.y_limit),
      .coord (sy)
   );

   nnsa_axis #(.DST_W(ZCOORD_W), .OUT_W(ZCOORD_W)) u_axis_z (
      .clock (clock),
      .dst   (req_dst_z),
      .ratio (cfg.ratio_z),
      .limit (cfg.z_limit),
      .coord (sz)
   );

   nnsa_offset u_offset (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (valid_ff[1]),
      .in_x       (sx),
      .in_y       (sy),
      .in_z       (sz),
      .cfg        (cfg),
      .out_valid  (rsp_valid),
      .out_x      (rsp_src_x),
      .out_y      (rsp_src_y),
      .out_z      (rsp_src_z),
      .out_offset (rsp_byte_offset)
   );

endmodule

@@ hw/rtl/nnsa_checker.sv @@
// Port-level checks for the scale address generator, bound to the top level.
// Depends on nnsa_pkg and nearest_neighbor_scale_address_core.
module nnsa_checker import nnsa_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [COORD_W-1:0]  rsp_src_x,
   input logic [COORD_W-1:0]  rsp_src_y,
   input logic [ZCOORD_W-1:0] rsp_src_z,
   input logic [OFF_W-1:0]    rsp_byte_offset
);

   // Every transfer is followed by its result strobe.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("transfer without a result five cycles later");

   // No result appears without a matching earlier transfer.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##5 !rsp_valid)
      else $error("result strobe without a matching transfer");

   // Reset flushes the pipeline.
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // The origin pixel always sits at offset zero.
   a_origin_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_src_x == '0 && rsp_src_y == '0 && rsp_src_z == '0)
      |-> rsp_byte_offset == '0)
      else $error("nonzero byte offset for the origin pixel");

endmodule

bind nearest_neighbor_scale_address_core nnsa_checker u_nnsa_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_src_x       (rsp_src_x),
   .rsp_src_y       (rsp_src_y),
   .rsp_src_z       (rsp_src_z),
   .rsp_byte_offset (rsp_byte_offset)
);
